### rtl/rc_frame_decoder_macros.svh
// Assertion macros for the frame decoder
`ifndef RC_FRAME_DECODER_MACROS_SVH
`define RC_FRAME_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define RCFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcfd assertion failed");
`define RCFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcfd assertion failed");
`else
`define RCFD_ASSERT_IMP(lbl, ante, cons)
`define RCFD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/rcfd_pkg.sv
package rcfd_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_SYNC_RD,
    ST_SYNC_CK,
    ST_CH_RD,
    ST_CH_CK,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    REG_THROTTLE  = 3'd0,
    REG_AILERON   = 3'd1,
    REG_ELEVATOR  = 3'd2,
    REG_RUDDER    = 3'd3,
    REG_MODE_ZERO = 3'd4,
    REG_MODE_ONE  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    CH_THROTTLE = 3'd0,
    CH_AILERON  = 3'd1,
    CH_ELEVATOR = 3'd2,
    CH_RUDDER   = 3'd3,
    CH_MODE     = 3'd4
  } chan_t;

  localparam logic [2:0] SYNC_LAST = 3'd4;
  localparam logic [4:0] DIV_LAST  = 5'd31;
  localparam logic [31:0] RANGE_RESET = 32'd134152192;

  localparam logic [7:0] SYNC_B0 = 8'h30;
  localparam logic [7:0] SYNC_B1 = 8'h00;
  localparam logic [7:0] SYNC_B5 = 8'hA2;
  localparam logic [7:0] SYNC_B8 = 8'h2B;
  localparam logic [7:0] SYNC_B9 = 8'hFE;

  function automatic logic [3:0] sync_off(input logic [2:0] k);
    logic [3:0] r;
    unique case (k)
      3'd0:    r = 4'd0;
      3'd1:    r = 4'd1;
      3'd2:    r = 4'd5;
      3'd3:    r = 4'd8;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sync_val(input logic [2:0] k);
    logic [7:0] r;
    unique case (k)
      3'd0:    r = SYNC_B0;
      3'd1:    r = SYNC_B1;
      3'd2:    r = SYNC_B5;
      3'd3:    r = SYNC_B8;
      default: r = SYNC_B9;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] chan_off(input chan_t c);
    logic [3:0] r;
    unique case (c)
      CH_THROTTLE: r = 4'd2;
      CH_AILERON:  r = 4'd6;
      CH_ELEVATOR: r = 4'd10;
      CH_RUDDER:   r = 4'd14;
      default:     r = 4'd12;
    endcase
    return r;
  endfunction

endpackage

### rtl/rc_frame_decoder.sv
// Byte item that does not complete a frame: written to the buffer, no result.
// Tick item: result registered from ST_TICK once the output register is free.
// Frame completion: sync search reads then compares each byte (ST_SYNC_RD, ST_SYNC_CK),
// then per axis high/low byte reads, a multiply, a divide (one quotient bit per cycle)
// and a finish step; the divide is skipped when the range span is zero.
// Reset (synchronous, rst_n low) clears control state; buffer is not cleared.
`include "rc_frame_decoder_macros.svh"

module rc_frame_decoder #(
  parameter int FRAME_BYTES    = 32,
  parameter int SEARCH_LIMIT   = 16,
  parameter int THROTTLE_SPAN  = 60000,
  parameter int AXIS_HALF_SPAN = 30000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic               out_frame_found,
  output logic [15:0]        out_throttle_out,
  output logic signed [15:0] out_aileron_out,
  output logic signed [15:0] out_elevator_out,
  output logic signed [15:0] out_rudder_out,
  output logic               out_mode_out,
  output logic               out_timeout_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int PW = $clog2(FRAME_BYTES);
  localparam int LAST_S_I = (SEARCH_LIMIT < FRAME_BYTES - 16) ? SEARCH_LIMIT : FRAME_BYTES - 16;
  localparam logic [PW-1:0] LAST_S   = PW'(LAST_S_I);
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);
  localparam logic [15:0] THR_SPAN = 16'(THROTTLE_SPAN);
  localparam logic [15:0] AX_SPAN  = 16'(2 * AXIS_HALF_SPAN);
  localparam logic signed [34:0] THR_HI = 35'(THROTTLE_SPAN);
  localparam logic signed [34:0] AX_HI  = 35'(AXIS_HALF_SPAN);
  localparam logic signed [34:0] AX_LO  = -AX_HI;

  rcfd_pkg::state_t state_r, state_nxt;
  rcfd_pkg::chan_t  c_r, c_nxt;
  logic [PW-1:0] pos_r, pos_nxt, s_r, s_nxt;
  logic [2:0]    k_r, k_nxt;
  logic          hi_r, hi_nxt;
  logic [15:0]   word_r, word_nxt;
  logic          neg_r, neg_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [15:0]   rem_r, rem_nxt, dv_r, dv_nxt;
  logic [4:0]    it_r, it_nxt;
  logic [15:0]   thr_r, thr_nxt, ail_r, ail_nxt, ele_r, ele_nxt, rud_r, rud_nxt;
  logic          mode_r, mode_nxt, tmo_r, tmo_nxt, fst_r, fst_nxt, found_r, found_nxt;
  logic [31:0]   thr_rng_r, ail_rng_r, ele_rng_r, rud_rng_r;
  logic [15:0]   code0_r, code1_r;
  logic          ov_r, ov_nxt;
  logic          o_kind_r, o_found_r, o_mode_r, o_tmo_r;
  logic [15:0]   o_thr_r, o_ail_r, o_ele_r, o_rud_r;

  logic          out_free, load_out, in_acc;
  logic          ram_we;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [31:0]   rng;
  logic [15:0]   mn, mx, mag, span;
  logic [16:0]   shifted;
  logic signed [34:0] qs, val, lo, hi;
  logic [15:0]   sat;
  logic [15:0]   full_word;

  assign cfg_ready = 1'b1;
  assign out_free  = !ov_r || out_ready;
  assign in_ready  = (state_r == rcfd_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign ram_we    = in_acc && !in_op;

  rcfd_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos_r),
    .wdata(in_rx_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcfd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_op) begin
            state_nxt = rcfd_pkg::ST_TICK;
          end else if (pos_r == LAST_POS) begin
            state_nxt = rcfd_pkg::ST_SYNC_RD;
          end
        end
      end
      rcfd_pkg::ST_TICK: if (out_free) state_nxt = rcfd_pkg::ST_IDLE;
      rcfd_pkg::ST_SYNC_RD: state_nxt = rcfd_pkg::ST_SYNC_CK;
      rcfd_pkg::ST_SYNC_CK: begin
        if (ram_rdata == rcfd_pkg::sync_val(k_r)) begin
          state_nxt = (k_r == rcfd_pkg::SYNC_LAST) ? rcfd_pkg::ST_CH_RD : rcfd_pkg::ST_SYNC_RD;
        end else begin
          state_nxt = (s_r == LAST_S) ? rcfd_pkg::ST_DONE : rcfd_pkg::ST_SYNC_RD;
        end
      end
      rcfd_pkg::ST_CH_RD: state_nxt = rcfd_pkg::ST_CH_CK;
      rcfd_pkg::ST_CH_CK: begin
        if (hi_r) begin
          state_nxt = rcfd_pkg::ST_CH_RD;
        end else begin
          state_nxt = (c_r == rcfd_pkg::CH_MODE) ? rcfd_pkg::ST_DONE : rcfd_pkg::ST_MUL;
        end
      end
      rcfd_pkg::ST_MUL: state_nxt = (dv_nxt == 16'd0) ? rcfd_pkg::ST_FIN : rcfd_pkg::ST_DIV;
      rcfd_pkg::ST_DIV: if (it_r == rcfd_pkg::DIV_LAST) state_nxt = rcfd_pkg::ST_FIN;
      rcfd_pkg::ST_FIN: state_nxt = rcfd_pkg::ST_CH_RD;
      rcfd_pkg::ST_DONE: if (out_free) state_nxt = rcfd_pkg::ST_IDLE;
      default: state_nxt = rcfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (c_r)
      rcfd_pkg::CH_THROTTLE: rng = thr_rng_r;
      rcfd_pkg::CH_AILERON:  rng = ail_rng_r;
      rcfd_pkg::CH_ELEVATOR: rng = ele_rng_r;
      default:               rng = rud_rng_r;
    endcase
    mn   = rng[15:0];
    mx   = rng[31:16];
    mag  = (word_r >= mn) ? word_r - mn : mn - word_r;
    span = (c_r == rcfd_pkg::CH_THROTTLE) ? THR_SPAN : AX_SPAN;
    lo   = (c_r == rcfd_pkg::CH_THROTTLE) ? 35'sd0 : AX_LO;
    hi   = (c_r == rcfd_pkg::CH_THROTTLE) ? THR_HI : AX_HI;
    shifted = {rem_r, quo_r[31]};
    qs   = neg_r ? -$signed({3'b000, quo_r}) : $signed({3'b000, quo_r});
    val  = qs + lo;
    if (val < lo) begin
      sat = lo[15:0];
    end else if (val > hi) begin
      sat = hi[15:0];
    end else begin
      sat = val[15:0];
    end
    full_word = {word_r[15:8], ram_rdata};
  end

  always_comb begin
    pos_nxt = pos_r;   s_nxt = s_r;     k_nxt = k_r;     c_nxt = c_r;
    hi_nxt = hi_r;     word_nxt = word_r; neg_nxt = neg_r; quo_nxt = quo_r;
    rem_nxt = rem_r;   dv_nxt = dv_r;   it_nxt = it_r;
    thr_nxt = thr_r;   ail_nxt = ail_r; ele_nxt = ele_r; rud_nxt = rud_r;
    mode_nxt = mode_r; tmo_nxt = tmo_r; fst_nxt = fst_r; found_nxt = found_r;
    ov_nxt = ov_r && !out_ready;
    load_out = 1'b0;
    ram_raddr = s_r + PW'(rcfd_pkg::sync_off(k_r));
    unique case (state_r)
      rcfd_pkg::ST_IDLE: begin
        if (ram_we) begin
          if (pos_r == LAST_POS) begin
            pos_nxt = '0;
            s_nxt = '0;
            k_nxt = '0;
            found_nxt = 1'b0;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      rcfd_pkg::ST_TICK: begin
        if (out_free) begin
          tmo_nxt = fst_r ? tmo_r : 1'b1;
          fst_nxt = 1'b0;
          load_out = 1'b1;
        end
      end
      rcfd_pkg::ST_SYNC_RD: ;
      rcfd_pkg::ST_SYNC_CK: begin
        if (ram_rdata == rcfd_pkg::sync_val(k_r)) begin
          if (k_r == rcfd_pkg::SYNC_LAST) begin
            c_nxt = rcfd_pkg::CH_THROTTLE;
            hi_nxt = 1'b1;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          k_nxt = '0;
          s_nxt = s_r + 1'b1;
        end
      end
      rcfd_pkg::ST_CH_RD, rcfd_pkg::ST_CH_CK: begin
        ram_raddr = s_r + PW'(rcfd_pkg::chan_off(c_r)) + PW'(!hi_r);
        if (state_r == rcfd_pkg::ST_CH_CK) begin
          hi_nxt = 1'b0;
          if (hi_r) begin
            word_nxt[15:8] = ram_rdata;
          end else begin
            word_nxt[7:0] = ram_rdata;
            if (c_r == rcfd_pkg::CH_MODE) begin
              found_nxt = 1'b1;
              if (full_word == code1_r) begin
                mode_nxt = 1'b1;
              end else if (full_word == code0_r) begin
                mode_nxt = 1'b0;
              end
            end
          end
        end
      end
      rcfd_pkg::ST_MUL: begin
        dv_nxt  = (mx >= mn) ? mx - mn : mn - mx;
        neg_nxt = (word_r < mn) ^ (mx < mn);
        quo_nxt = (dv_nxt == 16'd0) ? 32'd0 : {16'd0, mag} * {16'd0, span};
        rem_nxt = '0;
        it_nxt  = '0;
      end
      rcfd_pkg::ST_DIV: begin
        if (shifted >= {1'b0, dv_r}) begin
          rem_nxt = 16'(shifted - {1'b0, dv_r});
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = shifted[15:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        it_nxt = it_r + 1'b1;
      end
      rcfd_pkg::ST_FIN: begin
        unique case (c_r)
          rcfd_pkg::CH_THROTTLE: begin thr_nxt = sat; c_nxt = rcfd_pkg::CH_AILERON;  end
          rcfd_pkg::CH_AILERON:  begin ail_nxt = sat; c_nxt = rcfd_pkg::CH_ELEVATOR; end
          rcfd_pkg::CH_ELEVATOR: begin ele_nxt = sat; c_nxt = rcfd_pkg::CH_RUDDER;   end
          default:               begin rud_nxt = sat; c_nxt = rcfd_pkg::CH_MODE;     end
        endcase
        hi_nxt = 1'b1;
      end
      rcfd_pkg::ST_DONE: begin
        if (out_free) begin
          if (found_r) begin
            tmo_nxt = 1'b0;
            fst_nxt = 1'b1;
          end
          load_out = 1'b1;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rcfd_pkg::ST_IDLE;
      pos_r     <= '0;
      mode_r    <= 1'b0;
      tmo_r     <= 1'b1;
      fst_r     <= 1'b0;
      thr_r     <= '0;
      ail_r     <= '0;
      ele_r     <= '0;
      rud_r     <= '0;
      ov_r      <= 1'b0;
      thr_rng_r <= rcfd_pkg::RANGE_RESET;
      ail_rng_r <= rcfd_pkg::RANGE_RESET;
      ele_rng_r <= rcfd_pkg::RANGE_RESET;
      rud_rng_r <= rcfd_pkg::RANGE_RESET;
      code0_r   <= 16'd0;
      code1_r   <= 16'd1;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      mode_r  <= mode_nxt;
      tmo_r   <= tmo_nxt;
      fst_r   <= fst_nxt;
      thr_r   <= thr_nxt;
      ail_r   <= ail_nxt;
      ele_r   <= ele_nxt;
      rud_r   <= rud_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          rcfd_pkg::REG_THROTTLE:  thr_rng_r <= cfg_wdata;
          rcfd_pkg::REG_AILERON:   ail_rng_r <= cfg_wdata;
          rcfd_pkg::REG_ELEVATOR:  ele_rng_r <= cfg_wdata;
          rcfd_pkg::REG_RUDDER:    rud_rng_r <= cfg_wdata;
          rcfd_pkg::REG_MODE_ZERO: code0_r   <= cfg_wdata[15:0];
          rcfd_pkg::REG_MODE_ONE:  code1_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    k_r     <= k_nxt;
    c_r     <= c_nxt;
    hi_r    <= hi_nxt;
    word_r  <= word_nxt;
    neg_r   <= neg_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dv_r    <= dv_nxt;
    it_r    <= it_nxt;
    found_r <= found_nxt;
    if (load_out) begin
      o_kind_r  <= (state_r == rcfd_pkg::ST_TICK);
      o_found_r <= (state_r == rcfd_pkg::ST_DONE) && found_r;
      o_thr_r   <= thr_r;
      o_ail_r   <= ail_r;
      o_ele_r   <= ele_r;
      o_rud_r   <= rud_r;
      o_mode_r  <= mode_r;
      o_tmo_r   <= tmo_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_kind         = o_kind_r;
  assign out_frame_found  = o_found_r;
  assign out_throttle_out = o_thr_r;
  assign out_aileron_out  = o_ail_r;
  assign out_elevator_out = o_ele_r;
  assign out_rudder_out   = o_rud_r;
  assign out_mode_out     = o_mode_r;
  assign out_timeout_out  = o_tmo_r;

  `RCFD_ASSERT_IMP(a_div_nonzero, state_r == rcfd_pkg::ST_DIV, dv_r != 16'd0)
  `RCFD_ASSERT_IMP(a_found_clears_tmo, out_valid && out_frame_found, !out_timeout_out)
  `RCFD_ASSERT_IMP(a_thr_bound, out_valid, out_throttle_out <= THR_SPAN)
  `RCFD_ASSERT_NXT(a_tick_next, in_valid && in_ready && in_op, state_r == rcfd_pkg::ST_TICK)
  `RCFD_ASSERT_IMP(a_tick_kind, out_valid && out_kind, !out_frame_found)

endmodule

### rtl/rcfd_ram.sv
module rcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
